>>> sv/jch_pkg.sv
// Package for the jump consistent hash unit: control word type, micro-op and
// branch codes, the microprogram table and the arithmetic constants.
// No dependencies.
package jch_pkg;

	localparam int STEP_W = 3;
	localparam int OP_W   = 3;
	localparam int COND_W = 3;

	// Datapath micro-ops.
	localparam logic [OP_W-1:0] OP_NOP  = 3'd0;
	localparam logic [OP_W-1:0] OP_MUL0 = 3'd1;
	localparam logic [OP_W-1:0] OP_MUL1 = 3'd2;
	localparam logic [OP_W-1:0] OP_MUL2 = 3'd3;
	localparam logic [OP_W-1:0] OP_MUL3 = 3'd4;
	localparam logic [OP_W-1:0] OP_DIVI = 3'd5;
	localparam logic [OP_W-1:0] OP_DIVS = 3'd6;
	localparam logic [OP_W-1:0] OP_EMIT = 3'd7;

	// Sequencer branch conditions.
	localparam logic [COND_W-1:0] C_NEXT   = 3'd0;
	localparam logic [COND_W-1:0] C_FINISH = 3'd1;
	localparam logic [COND_W-1:0] C_DONE   = 3'd2;
	localparam logic [COND_W-1:0] C_SAT    = 3'd3;
	localparam logic [COND_W-1:0] C_LOOP   = 3'd4;

	// Program addresses.
	localparam logic [STEP_W-1:0] S_CHECK = 3'd0;
	localparam logic [STEP_W-1:0] S_EMIT  = 3'd7;

	// Linear congruential multiplier, split into 32-bit halves.
	localparam logic [31:0] MULT_HI = 32'h27BB2EE6;
	localparam logic [31:0] MULT_LO = 32'h87B0B0FD;

	// Quotient saturation value and the start value of the quotient bit counter.
	localparam logic [31:0] J_CAP   = 32'h8000_0000;
	localparam logic [4:0]  DIV_LAST = 5'd30;

	typedef struct packed {
		logic [OP_W-1:0]   op;
		logic [COND_W-1:0] cond;
		logic [STEP_W-1:0] target;
	} ctrl_t;

	typedef struct packed {
		logic loop_done;
		logic sat;
		logic cnt_nz;
	} status_t;

	function automatic ctrl_t ucode(input logic [STEP_W-1:0] addr);
		ctrl_t w;
		w = '{op: OP_NOP, cond: C_NEXT, target: S_CHECK};
		case (addr)
			3'd0: w = '{op: OP_NOP,  cond: C_DONE,   target: S_EMIT};
			3'd1: w = '{op: OP_MUL0, cond: C_NEXT,   target: S_CHECK};
			3'd2: w = '{op: OP_MUL1, cond: C_NEXT,   target: S_CHECK};
			3'd3: w = '{op: OP_MUL2, cond: C_NEXT,   target: S_CHECK};
			3'd4: w = '{op: OP_MUL3, cond: C_NEXT,   target: S_CHECK};
			3'd5: w = '{op: OP_DIVI, cond: C_SAT,    target: S_CHECK};
			3'd6: w = '{op: OP_DIVS, cond: C_LOOP,   target: S_CHECK};
			3'd7: w = '{op: OP_EMIT, cond: C_FINISH, target: S_CHECK};
			default: w = '{op: OP_NOP, cond: C_FINISH, target: S_CHECK};
		endcase
		return w;
	endfunction

endpackage

>>> sv/jch_datapath.sv
// Datapath of the jump consistent hash unit: key register, shared 32x32
// multiplier with accumulator, and a one-bit-per-cycle restoring divider.
// Depends on jch_pkg.
module jch_datapath (
	input  logic             clk,
	input  logic             load,
	input  logic [63:0]      key,
	input  logic [30:0]      count,
	input  jch_pkg::ctrl_t   ctrl,
	output jch_pkg::status_t status,
	output logic [30:0]      bucket
);

	logic [63:0] key_q;
	logic [63:0] prod_q;
	logic [63:0] acc_q;
	logic [30:0] b_q;
	logic [31:0] j_q;
	logic [30:0] rem_q;
	logic [30:0] quo_q;
	logic [4:0]  cnt_q;
	logic [30:0] bucket_q;

	logic [31:0] mul_a;
	logic [31:0] mul_b;
	logic [63:0] mul_p;
	logic [30:0] count_eff;
	logic [31:0] bp1;
	logic [31:0] den;
	logic [31:0] rem2;
	logic        ge;
	logic [31:0] rem_sub;
	logic [30:0] quo_next;

	always_comb begin
		mul_a = key_q[31:0];
		mul_b = jch_pkg::MULT_LO;
		case (ctrl.op)
			jch_pkg::OP_MUL1: begin
				mul_b = jch_pkg::MULT_HI;
			end
			jch_pkg::OP_MUL2: begin
				mul_a = key_q[63:32];
			end
			default: begin
				mul_a = key_q[31:0];
				mul_b = jch_pkg::MULT_LO;
			end
		endcase
	end

	assign mul_p = {32'd0, mul_a} * {32'd0, mul_b};

	// A bucket count of zero behaves like a count of one.
	assign count_eff = (count == 31'd0) ? 31'd1 : count;
	assign bp1       = {1'b0, b_q} + 32'd1;
	assign den       = {1'b0, key_q[63:33]} + 32'd1;
	assign rem2      = {rem_q, 1'b0};
	assign ge        = (rem2 >= den);
	assign rem_sub   = ge ? (rem2 - den) : rem2;
	assign quo_next  = {quo_q[29:0], ge};

	assign status = '{loop_done: (j_q >= {1'b0, count_eff}),
	                  sat:       (bp1 >= den),
	                  cnt_nz:    (cnt_q != 5'd0)};

	always_ff @(posedge clk) begin
		if (load) begin
			key_q <= key;
			b_q   <= '0;
			j_q   <= '0;
		end else begin
			case (ctrl.op)
				jch_pkg::OP_MUL0: begin
					prod_q <= mul_p;
					b_q    <= j_q[30:0];
				end
				jch_pkg::OP_MUL1: begin
					acc_q  <= prod_q + 64'd1;
					prod_q <= mul_p;
				end
				jch_pkg::OP_MUL2: begin
					acc_q  <= acc_q + {prod_q[31:0], 32'd0};
					prod_q <= mul_p;
				end
				jch_pkg::OP_MUL3: begin
					key_q <= acc_q + {prod_q[31:0], 32'd0};
				end
				jch_pkg::OP_DIVI: begin
					// When b+1 reaches the divisor the quotient is at least 2^31.
					if (bp1 >= den) begin
						j_q <= jch_pkg::J_CAP;
					end else begin
						rem_q <= bp1[30:0];
						quo_q <= '0;
						cnt_q <= jch_pkg::DIV_LAST;
					end
				end
				jch_pkg::OP_DIVS: begin
					rem_q <= rem_sub[30:0];
					quo_q <= quo_next;
					cnt_q <= cnt_q - 5'd1;
					if (cnt_q == 5'd0) begin
						j_q <= {1'b0, quo_next};
					end
				end
				jch_pkg::OP_EMIT: begin
					bucket_q <= b_q;
				end
				default: begin
				end
			endcase
		end
	end

	assign bucket = bucket_q;

endmodule

>>> sv/jump_consistent_hash_unit.sv
// Top level of the jump consistent hash unit: APB register, command handshake
// and the microprogram sequencer. Depends on jch_pkg and jch_datapath.
//
// An item is taken when start is high and busy is low; its bucket appears on
// bucket with done high for one cycle, and the receiver cannot stall it. A
// key runs about ln(bucket_count)+1 jump iterations, then a final check step
// and the emit step. Each iteration has one check step, four steps through the
// shared 32x32 multiplier for the 64-bit key update, one saturation test and
// 31 steps of the bit-serial divider; iterations whose quotient saturates
// skip the divider.
module jump_consistent_hash_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	input  logic        start,
	output logic        busy,
	input  logic [63:0] key,
	output logic        done,
	output logic [30:0] bucket
);

	logic [30:0]                 bucket_count_q;
	logic                        busy_q;
	logic                        done_q;
	logic [jch_pkg::STEP_W-1:0]  step_q;
	jch_pkg::ctrl_t              ctrl;
	jch_pkg::status_t            status;
	logic                        load;

	assign pready = 1'b1;
	assign prdata = {1'b0, bucket_count_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bucket_count_q <= 31'd1;
		end else if (psel && penable && pwrite && !paddr[2]) begin
			bucket_count_q <= pwdata[30:0];
		end
	end

	assign load = start && !busy_q;

	always_comb begin
		if (busy_q) begin
			ctrl = jch_pkg::ucode(step_q);
		end else begin
			ctrl = '{op: jch_pkg::OP_NOP, cond: jch_pkg::C_NEXT,
			         target: jch_pkg::S_CHECK};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= jch_pkg::S_CHECK;
		end else begin
			done_q <= busy_q && (ctrl.op == jch_pkg::OP_EMIT);
			if (load) begin
				busy_q <= 1'b1;
				step_q <= jch_pkg::S_CHECK;
			end else if (busy_q) begin
				case (ctrl.cond)
					jch_pkg::C_FINISH: begin
						busy_q <= 1'b0;
						step_q <= ctrl.target;
					end
					jch_pkg::C_DONE: begin
						step_q <= status.loop_done ? ctrl.target : step_q + 3'd1;
					end
					jch_pkg::C_SAT: begin
						step_q <= status.sat ? ctrl.target : step_q + 3'd1;
					end
					jch_pkg::C_LOOP: begin
						// The divide step repeats until its bit counter runs out.
						step_q <= status.cnt_nz ? step_q : ctrl.target;
					end
					default: begin
						step_q <= step_q + 3'd1;
					end
				endcase
			end
		end
	end

	jch_datapath u_datapath (
		.clk    (clk),
		.load   (load),
		.key    (key),
		.count  (bucket_count_q),
		.ctrl   (ctrl),
		.status (status),
		.bucket (bucket)
	);

	assign busy = busy_q;
	assign done = done_q;

endmodule
